### design/srxe_pkg.sv
// Shared types, constants and helper functions for the sprite row x-zoom expander.
package srxe_pkg;

  localparam int unsigned LaneNum  = 16;
  localparam int unsigned PixW     = 4;
  localparam int unsigned LaneIdxW = $clog2(LaneNum);
  localparam int unsigned RowW     = LaneNum * PixW;
  localparam int unsigned ZoomW    = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned PalW     = 8;
  localparam int unsigned PenW     = 12;
  localparam int unsigned XW       = 10;
  localparam int unsigned YW       = 9;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 120;

  // Rows at or left of this x are entirely off screen.
  localparam logic signed [XW-1:0] SkipLimit = -10'sd16;

  // Bit p set: drawing position p survives at this zoom.
  localparam logic [LaneNum-1:0] KeepRows [LaneNum] = '{
    16'h0100, 16'h0110, 16'h1110, 16'h1114,
    16'h5114, 16'h5154, 16'h5554, 16'h5555,
    16'h5755, 16'h575D, 16'hD75D, 16'hD7DD,
    16'hF7DD, 16'hF7DF, 16'hFFDF, 16'hFFFF
  };

  typedef struct packed {
    logic                keep;
    logic [LaneIdxW-1:0] slot;
    logic [PixW-1:0]     pix;
  } lane_res_t;

  // Packed-slot index of a drawing position: survivors to its left.
  function automatic logic [LaneIdxW-1:0] slot_of(input logic [ZoomW-1:0] zoom,
                                                  input logic [LaneIdxW-1:0] pos);
    logic [LaneNum-1:0] below;
    below = KeepRows[zoom] & ((LaneNum'(1) << pos) - LaneNum'(1));
    return LaneIdxW'($countones(below));
  endfunction

endpackage

### design/srxe_lane.sv
// One drawing-position lane: mirror, keep test and slot index for a single pixel.
module srxe_lane (
  input  logic [srxe_pkg::RowW-1:0]     row_pixels_i,
  input  logic                          flip_x_i,
  input  logic [srxe_pkg::ZoomW-1:0]    zoom_x_i,
  input  logic [srxe_pkg::LaneIdxW-1:0] lane_idx_i,
  output srxe_pkg::lane_res_t           res_o
);
  import srxe_pkg::*;

  logic [LaneIdxW-1:0] src;

  // Mirrored position 15-p is the bitwise inverse of p.
  assign src        = flip_x_i ? ~lane_idx_i : lane_idx_i;
  assign res_o.pix  = row_pixels_i[src*PixW +: PixW];
  assign res_o.keep = KeepRows[zoom_x_i][lane_idx_i];
  assign res_o.slot = slot_of(zoom_x_i, lane_idx_i);

endmodule

### design/srxe_merge.sv
// Merge stage: scatter the surviving lane pixels into packed slots and build the mask.
module srxe_merge (
  input  srxe_pkg::lane_res_t         lanes_i [srxe_pkg::LaneNum],
  input  logic                        skip_i,
  output logic [srxe_pkg::RowW-1:0]   packed_o,
  output logic [srxe_pkg::LaneNum-1:0] mask_o
);
  import srxe_pkg::*;

  always_comb begin
    packed_o = '0;
    mask_o   = '0;
    for (int p = 0; p < LaneNum; p++) begin
      if (lanes_i[p].keep && !skip_i) begin
        packed_o[lanes_i[p].slot*PixW +: PixW] = packed_o[lanes_i[p].slot*PixW +: PixW]
                                               | lanes_i[p].pix;
        mask_o[lanes_i[p].slot] = mask_o[lanes_i[p].slot] | (lanes_i[p].pix != '0);
      end
    end
  end

endmodule

### design/sprite_row_xzoom_expander_unit.sv
// Top level of the sprite row x-zoom expander: lanes, merge and two-stage stream pipeline.
//
//  channel   dir  fields (tdata, lowest bit up)
//  s_axis    in   row_pixels[63:0] flip_x[64] zoom_x[68:65] palette[76:69]
//                 start_x[86:77] line_y[95:87]
//  m_axis    out  packed_pixels[63:0] write_mask[79:64] pixel_count[84:80]
//                 pen_base[96:85] out_x[106:97] out_y[115:107] skipped[116]
//
// One row per cycle sustained while m_axis_tready stays high; an accepted row is registered
// in stage one, then in stage two, whose valid flag drives m_axis_tvalid.
// Stage one registers the sixteen lane results, stage two registers the merged row.
// Reset clears both stage valid flags only; payload registers carry no reset.
// Each stage advances when it is empty or the stage behind it takes its
// transaction, so a new row is taken while a finished result waits downstream.
module sprite_row_xzoom_expander_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // row_pixels, flip_x, zoom_x, palette, start_x, line_y
  input  logic [srxe_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // packed_pixels, write_mask, pixel_count, pen_base, out_x, out_y, skipped, zero pad
  output logic [srxe_pkg::OutDataW-1:0]   m_axis_tdata
);
  import srxe_pkg::*;

  // Unpack the incoming transaction.
  logic [RowW-1:0]     in_row;
  logic                in_flip;
  logic [ZoomW-1:0]    in_zoom;
  logic [PalW-1:0]     in_pal;
  logic [XW-1:0]       in_x;
  logic [YW-1:0]       in_y;

  assign in_row  = s_axis_tdata[63:0];
  assign in_flip = s_axis_tdata[64];
  assign in_zoom = s_axis_tdata[68:65];
  assign in_pal  = s_axis_tdata[76:69];
  assign in_x    = s_axis_tdata[86:77];
  assign in_y    = s_axis_tdata[95:87];

  // Lanes: one per drawing position, all working on the same row.
  lane_res_t lane_res [LaneNum];

  for (genvar g = 0; g < LaneNum; g++) begin : g_lane
    srxe_lane u_lane (
      .row_pixels_i (in_row),
      .flip_x_i     (in_flip),
      .zoom_x_i     (in_zoom),
      .lane_idx_i   (LaneIdxW'(g)),
      .res_o        (lane_res[g])
    );
  end

  // Stage one: lane results and side fields.
  logic                s1_v_q, s1_v_d;
  lane_res_t           lanes_q [LaneNum];
  logic                skip_q;
  logic [ZoomW-1:0]    zoom_q;
  logic [PalW-1:0]     pal_q;
  logic [XW-1:0]       x_q;
  logic [YW-1:0]       y_q;

  // Stage two: output register.
  logic                out_v_q, out_v_d;
  logic [RowW-1:0]     packed_q;
  logic [LaneNum-1:0]  mask_q;
  logic [CountW-1:0]   count_q;
  logic [PenW-1:0]     pen_q;
  logic [XW-1:0]       ox_q;
  logic [YW-1:0]       oy_q;
  logic                oskip_q;

  logic                s2_ready;
  logic                s1_ready;
  logic                s1_load;
  logic                s2_load;

  // Hold a stage unless it is empty or its transaction moves on.
  assign s2_ready      = !out_v_q || m_axis_tready;
  assign s1_ready      = !s1_v_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign s1_load       = s_axis_tvalid && s1_ready;
  assign s2_load       = s1_v_q && s2_ready;

  assign s1_v_d  = s1_load ? 1'b1 : (s2_ready ? 1'b0 : s1_v_q);
  assign out_v_d = s2_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_v_q);

  // Merge the registered lanes into packed slots.
  logic [RowW-1:0]     mrg_packed;
  logic [LaneNum-1:0]  mrg_mask;

  srxe_merge u_merge (
    .lanes_i  (lanes_q),
    .skip_i   (skip_q),
    .packed_o (mrg_packed),
    .mask_o   (mrg_mask)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      lanes_q <= lane_res;
      skip_q  <= ($signed(in_x) <= SkipLimit);
      zoom_q  <= in_zoom;
      pal_q   <= in_pal;
      x_q     <= in_x;
      y_q     <= in_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      packed_q <= mrg_packed;
      mask_q   <= mrg_mask;
      count_q  <= CountW'(zoom_q) + CountW'(1);
      pen_q    <= {pal_q, {PixW{1'b0}}};
      ox_q     <= x_q;
      oy_q     <= y_q;
      oskip_q  <= skip_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, oskip_q, oy_q, ox_q, pen_q, count_q, mask_q, packed_q};

endmodule

### sim/tb_sprite_row_xzoom_expander_unit.sv
// Self-checking testbench for the sprite row x-zoom expander stream pipeline.

typedef struct packed {
  logic [8:0]        line_y;
  logic signed [9:0] start_x;
  logic [7:0]        palette;
  logic [3:0]        zoom_x;
  logic              flip_x;
  logic [63:0]       row_pixels;
} row_in_t;

typedef struct packed {
  logic [2:0]        pad;
  logic              skipped;
  logic [8:0]        out_y;
  logic signed [9:0] out_x;
  logic [11:0]       pen_base;
  logic [4:0]        pixel_count;
  logic [15:0]       write_mask;
  logic [63:0]       packed_pixels;
} row_out_t;

class sprite_row_checker;
  row_out_t rows_due[$];
  int errors;
  int checked;
  int skipped_rows;

  // Survivor pattern for each zoom: bit p keeps drawing position p.
  function logic [15:0] keep_mask(input logic [3:0] zoom);
    case (zoom)
      4'd0:  return 16'h0100;
      4'd1:  return 16'h0110;
      4'd2:  return 16'h1110;
      4'd3:  return 16'h1114;
      4'd4:  return 16'h5114;
      4'd5:  return 16'h5154;
      4'd6:  return 16'h5554;
      4'd7:  return 16'h5555;
      4'd8:  return 16'h5755;
      4'd9:  return 16'h575D;
      4'd10: return 16'hD75D;
      4'd11: return 16'hD7DD;
      4'd12: return 16'hF7DD;
      4'd13: return 16'hF7DF;
      4'd14: return 16'hFFDF;
      default: return 16'hFFFF;
    endcase
  endfunction

  function row_out_t expand_row(input row_in_t r);
    row_out_t    o;
    logic [15:0] keep;
    logic [3:0]  pix;
    int          slot;
    int          src;
    o    = '0;
    keep = keep_mask(r.zoom_x);
    slot = 0;
    o.skipped = ($signed(r.start_x) <= -16);
    if (!o.skipped) begin
      for (int p = 0; p < 16; p++) begin
        if (keep[p]) begin
          src = r.flip_x ? 15 - p : p;
          pix = r.row_pixels[4*src +: 4];
          o.packed_pixels[4*slot +: 4] = pix;
          if (pix != 4'h0) o.write_mask[slot] = 1'b1;
          slot++;
        end
      end
    end
    o.pixel_count = {1'b0, r.zoom_x} + 5'd1;
    o.pen_base    = {r.palette, 4'h0};
    o.out_x       = r.start_x;
    o.out_y       = r.line_y;
    return o;
  endfunction

  function int pending();
    return rows_due.size();
  endfunction

  function void note_row(input row_in_t r);
    rows_due.push_back(expand_row(r));
  endfunction

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] result %0d: %s got %h expected %h", $time, checked, what, got, want);
    errors++;
  endtask

  task check_row(input row_out_t got);
    row_out_t want;
    if (rows_due.size() == 0) begin
      report_mismatch("result with nothing outstanding", got.packed_pixels, '0);
      return;
    end
    want = rows_due.pop_front();
    if (got.packed_pixels !== want.packed_pixels)
      report_mismatch("packed_pixels", got.packed_pixels, want.packed_pixels);
    if (got.write_mask !== want.write_mask)
      report_mismatch("write_mask", got.write_mask, want.write_mask);
    if (got.pixel_count !== want.pixel_count)
      report_mismatch("pixel_count", got.pixel_count, want.pixel_count);
    if (got.pen_base !== want.pen_base)
      report_mismatch("pen_base", got.pen_base, want.pen_base);
    if (got.out_x !== want.out_x)
      report_mismatch("out_x", got.out_x, want.out_x);
    if (got.out_y !== want.out_y)
      report_mismatch("out_y", got.out_y, want.out_y);
    if (got.skipped !== want.skipped)
      report_mismatch("skipped", got.skipped, want.skipped);
    if (got.pad !== 3'b000)
      report_mismatch("padding", got.pad, '0);
    if (want.skipped) skipped_rows++;
    checked++;
  endtask
endclass

module tb_sprite_row_xzoom_expander_unit;

  localparam int RandomRows = 1100;
  localparam int CalmTail   = 150;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // row_pixels, flip_x, zoom_x, palette, start_x, line_y
  logic [srxe_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // packed_pixels, write_mask, pixel_count, pen_base, out_x, out_y, skipped, zero pad
  logic [srxe_pkg::OutDataW-1:0] m_axis_tdata;

  sprite_row_checker board = new();

  // Percentage chance that either side starts an idle burst: per cycle for results, per row for the sender.
  int idle_pct = 0;
  int stall_left = 0;
  int rows_sent = 0;

  sprite_row_xzoom_expander_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Present one row and hold it until the transaction completes.
  task put_row(input logic [63:0] px, input logic fl, input logic [3:0] zoom,
               input logic [7:0] pal, input logic [9:0] sx, input logic [8:0] ly);
    row_in_t r;
    r.row_pixels = px;
    r.flip_x     = fl;
    r.zoom_x     = zoom;
    r.palette    = pal;
    r.start_x    = sx;
    r.line_y     = ly;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_row(r);
    rows_sent++;
  endtask

  task idle_in(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task drain_rows();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: check each transaction, then decide the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_row(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [63:0] px;
    logic [63:0] holes;
    int          v;
    logic [9:0]  sx;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every zoom with distinct nibbles, so dropped and mirrored positions show.
    for (int z = 0; z < 16; z++)
      put_row(64'hFEDC_BA98_7654_3210, z[0], z[3:0], 8'(z * 17), 10'(z * 31), 9'(z * 33));
    // Full width both ways, opaque and transparent rows, field extremes.
    put_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'hF, 8'hFF, 10'sd511, 9'd511);
    put_row(64'h0123_4567_89AB_CDEF, 1'b0, 4'hF, 8'h00, 10'sd0, 9'd0);
    put_row(64'h0000_0000_0000_0000, 1'b0, 4'hF, 8'h5A, 10'sd100, 9'd256);
    put_row(64'hF0F0_0F0F_00FF_FF00, 1'b1, 4'h7, 8'hA5, 10'sd1, 9'd1);
    // Skip threshold: -15 draws, -16 and below do not.
    put_row(64'h1111_2222_3333_4444, 1'b0, 4'hF, 8'h3C, -10'sd15, 9'd100);
    put_row(64'h1111_2222_3333_4444, 1'b0, 4'hF, 8'h3C, -10'sd16, 9'd101);
    put_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'h0, 8'hFF, -10'sd512, 9'd511);
    put_row(64'hDEAD_BEEF_CAFE_F00D, 1'b1, 4'h9, 8'h81, -10'sd17, 9'd3);

    // Hold the sender off until the pipeline has emptied.
    drain_rows();

    for (int i = 0; i < RandomRows; i++) begin
      if (i >= RandomRows - CalmTail) idle_pct = 0;
      else idle_pct = ((i / 120) % 3 == 2) ? 0 : 25;

      if (i == RandomRows / 2) drain_rows();
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) idle_in($urandom_range(1, 4));

      px = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: begin
          // Punch transparent holes into the row.
          holes = {$urandom, $urandom};
          for (int n = 0; n < 16; n++)
            if (holes[n]) px[4*n +: 4] = 4'h0;
        end
        1: begin
          for (int n = 0; n < 16; n++)
            px[4*n +: 4] = px[4*n] ? 4'hF : 4'h0;
        end
        default: ;
      endcase

      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 40) - 28;
        default: v = $urandom_range(0, 526) - 15;
      endcase
      sx = v[9:0];

      put_row(px, 1'($urandom), 4'($urandom), 8'($urandom), sx, 9'($urandom));
    end

    drain_rows();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d rows over every zoom and both flip settings; checked %0d results.",
             rows_sent, board.checked);
    $display("%0d rows fell on the off-screen path, %0d mismatches.",
             board.skipped_rows, board.errors);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", board.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule
